>>> hdl/rhsv_pkg.sv
// Package for the RGB to HSV converter: widths, pipeline depth and hue sector codes.
package rhsv_pkg;

    // component width and fraction width of hue and saturation
    localparam int COMP_BITS  = 8;
    localparam int FRAC_BITS  = 16;

    // 6 * delta needs three more bits than a component
    localparam int HDIV_BITS  = COMP_BITS + 3;
    // signed hue numerator before wrap
    localparam int NUM_BITS   = COMP_BITS + 4;
    // saturation dividend delta * (2^FRAC_BITS - 1)
    localparam int SDIV_BITS  = COMP_BITS + FRAC_BITS;

    // one quotient bit per divider stage
    localparam int DIV_STAGES = FRAC_BITS;
    // two front stages, the divider stages and the output register
    localparam int LATENCY    = DIV_STAGES + 3;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } t_sector;

endpackage

>>> hdl/rgb_to_hsv_converter_top.sv
// RGB to HSV converter: pipelined max/min, hue numerator and two restoring dividers.
//
//  channel   ports                                    handshake
//  -------   --------------------------------------   ------------------------------
//  request   i_red, i_green, i_blue                   start, accepted when !busy
//  result    o_hue, o_hue_valid, o_saturation,        o_done, one cycle, no stall
//            o_value
//
// One request per clock cycle; busy is always low. Each result passes through one stage for
// max/min and the sector, one for delta, the hue numerator and the saturation dividend,
// sixteen divider stages (one quotient bit each for hue and saturation side by side) and
// the output register.
// Reset clears the valid bits of all stages; data registers carry no reset.
// The receiver cannot stall, so the pipeline never holds.
module rgb_to_hsv_converter_top
    import rhsv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [COMP_BITS-1:0] i_red,
    input  logic [COMP_BITS-1:0] i_green,
    input  logic [COMP_BITS-1:0] i_blue,
    output logic                 o_done,
    output logic [FRAC_BITS-1:0] o_hue,
    output logic                 o_hue_valid,
    output logic [FRAC_BITS-1:0] o_saturation,
    output logic [COMP_BITS-1:0] o_value
);

    // stage A: max, min, sector
    logic                 r_a_vld;
    logic [COMP_BITS-1:0] r_a_red, r_a_green, r_a_blue, r_a_mx, r_a_mn;
    t_sector              r_a_sect;
    logic [COMP_BITS-1:0] n_a_mx, n_a_mn;
    t_sector              n_a_sect;

    // stage B: divider operands
    logic                 r_b_vld;
    logic [HDIV_BITS-1:0] r_b_hrem, r_b_d6;
    logic [COMP_BITS-1:0] r_b_srem, r_b_mx;
    logic [FRAC_BITS-1:0] r_b_slo;
    logic                 r_b_chrom;
    logic [HDIV_BITS-1:0] n_b_hrem, n_b_d6;
    logic [COMP_BITS-1:0] n_b_srem;
    logic [FRAC_BITS-1:0] n_b_slo;

    // divider stages
    logic                 r_vld   [DIV_STAGES];
    logic [HDIV_BITS-1:0] r_hrem  [DIV_STAGES];
    logic [HDIV_BITS-1:0] r_d6    [DIV_STAGES];
    logic [FRAC_BITS-1:0] r_hq    [DIV_STAGES];
    logic [COMP_BITS-1:0] r_srem  [DIV_STAGES];
    logic [COMP_BITS-1:0] r_mx    [DIV_STAGES];
    logic [FRAC_BITS-1:0] r_slo   [DIV_STAGES];
    logic [FRAC_BITS-1:0] r_sq    [DIV_STAGES];
    logic                 r_chrom [DIV_STAGES];
    logic [HDIV_BITS-1:0] n_hrem  [DIV_STAGES];
    logic [FRAC_BITS-1:0] n_hq    [DIV_STAGES];
    logic [COMP_BITS-1:0] n_srem  [DIV_STAGES];
    logic [FRAC_BITS-1:0] n_slo   [DIV_STAGES];
    logic [FRAC_BITS-1:0] n_sq    [DIV_STAGES];

    // output register
    logic                 r_o_done;
    logic [FRAC_BITS-1:0] r_o_hue, r_o_sat;
    logic                 r_o_hvalid;
    logic [COMP_BITS-1:0] r_o_value;

    logic                 accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // stage A: red wins ties over green, green over blue
    always_comb begin
        n_a_mx = i_red;
        n_a_mn = i_red;
        if (i_green > n_a_mx) n_a_mx = i_green;
        if (i_blue  > n_a_mx) n_a_mx = i_blue;
        if (i_green < n_a_mn) n_a_mn = i_green;
        if (i_blue  < n_a_mn) n_a_mn = i_blue;
        priority if (i_red >= i_green && i_red >= i_blue) begin
            n_a_sect = SECT_RED;
        end else if (i_green >= i_blue) begin
            n_a_sect = SECT_GREEN;
        end else begin
            n_a_sect = SECT_BLUE;
        end
    end

    // stage B: delta, wrapped hue numerator, saturation dividend
    always_comb begin
        logic [COMP_BITS-1:0]       delta;
        logic signed [NUM_BITS-1:0] ext_r, ext_g, ext_b, ext_d, ext_d6, num;
        logic [SDIV_BITS-1:0]       sdiv;
        delta  = r_a_mx - r_a_mn;
        n_b_d6 = HDIV_BITS'({delta, 2'b00}) + HDIV_BITS'({delta, 1'b0});
        ext_r  = $signed({{(NUM_BITS-COMP_BITS){1'b0}}, r_a_red});
        ext_g  = $signed({{(NUM_BITS-COMP_BITS){1'b0}}, r_a_green});
        ext_b  = $signed({{(NUM_BITS-COMP_BITS){1'b0}}, r_a_blue});
        ext_d  = $signed({{(NUM_BITS-COMP_BITS){1'b0}}, delta});
        ext_d6 = $signed({{(NUM_BITS-HDIV_BITS){1'b0}}, n_b_d6});
        unique case (r_a_sect)
            SECT_RED:   num = ext_g - ext_b;
            SECT_GREEN: num = (ext_d <<< 1) + ext_b - ext_r;
            SECT_BLUE:  num = (ext_d <<< 2) + ext_r - ext_g;
            default:    num = '0;
        endcase
        // wrap a negative hue by one full turn
        if (num[NUM_BITS-1]) num = num + ext_d6;
        n_b_hrem = num[HDIV_BITS-1:0];
        sdiv     = {delta, {FRAC_BITS{1'b0}}} - SDIV_BITS'(delta);
        n_b_srem = sdiv[SDIV_BITS-1:FRAC_BITS];
        n_b_slo  = sdiv[FRAC_BITS-1:0];
    end

    // restoring division, one quotient bit per stage for hue and saturation
    always_comb begin
        logic [HDIV_BITS-1:0] s_hrem, s_d6;
        logic [FRAC_BITS-1:0] s_hq, s_slo, s_sq;
        logic [COMP_BITS-1:0] s_srem, s_mx;
        logic [HDIV_BITS:0]   ht;
        logic [COMP_BITS:0]   st;
        logic                 hbit, sbit;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                s_hrem = r_b_hrem;
                s_d6   = r_b_d6;
                s_hq   = '0;
                s_srem = r_b_srem;
                s_mx   = r_b_mx;
                s_slo  = r_b_slo;
                s_sq   = '0;
            end else begin
                s_hrem = r_hrem[k-1];
                s_d6   = r_d6[k-1];
                s_hq   = r_hq[k-1];
                s_srem = r_srem[k-1];
                s_mx   = r_mx[k-1];
                s_slo  = r_slo[k-1];
                s_sq   = r_sq[k-1];
            end
            ht   = {s_hrem, 1'b0};
            hbit = (ht >= {1'b0, s_d6});
            if (hbit) begin
                n_hrem[k] = HDIV_BITS'(ht - {1'b0, s_d6});
            end else begin
                n_hrem[k] = ht[HDIV_BITS-1:0];
            end
            n_hq[k] = {s_hq[FRAC_BITS-2:0], hbit};

            st   = {s_srem, s_slo[FRAC_BITS-1]};
            sbit = (st >= {1'b0, s_mx});
            if (sbit) begin
                n_srem[k] = COMP_BITS'(st - {1'b0, s_mx});
            end else begin
                n_srem[k] = st[COMP_BITS-1:0];
            end
            n_slo[k] = {s_slo[FRAC_BITS-2:0], 1'b0};
            n_sq[k]  = {s_sq[FRAC_BITS-2:0], sbit};
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_o_done <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++) r_vld[k] <= 1'b0;
        end else begin
            r_a_vld  <= accept;
            r_b_vld  <= r_a_vld;
            r_vld[0] <= r_b_vld;
            for (int k = 1; k < DIV_STAGES; k++) r_vld[k] <= r_vld[k-1];
            r_o_done <= r_vld[DIV_STAGES-1];
        end
    end

    // data path
    always_ff @(posedge i_clk) begin
        r_a_red   <= i_red;
        r_a_green <= i_green;
        r_a_blue  <= i_blue;
        r_a_mx    <= n_a_mx;
        r_a_mn    <= n_a_mn;
        r_a_sect  <= n_a_sect;

        r_b_hrem  <= n_b_hrem;
        r_b_d6    <= n_b_d6;
        r_b_srem  <= n_b_srem;
        r_b_slo   <= n_b_slo;
        r_b_mx    <= r_a_mx;
        r_b_chrom <= (r_a_mx != r_a_mn);

        for (int k = 0; k < DIV_STAGES; k++) begin
            r_hrem[k] <= n_hrem[k];
            r_hq[k]   <= n_hq[k];
            r_srem[k] <= n_srem[k];
            r_slo[k]  <= n_slo[k];
            r_sq[k]   <= n_sq[k];
        end
        r_d6[0]    <= r_b_d6;
        r_mx[0]    <= r_b_mx;
        r_chrom[0] <= r_b_chrom;
        for (int k = 1; k < DIV_STAGES; k++) begin
            r_d6[k]    <= r_d6[k-1];
            r_mx[k]    <= r_mx[k-1];
            r_chrom[k] <= r_chrom[k-1];
        end

        // drop the quotients of an achromatic pixel
        r_o_hvalid <= r_chrom[DIV_STAGES-1];
        r_o_hue    <= r_chrom[DIV_STAGES-1] ? r_hq[DIV_STAGES-1] : '0;
        r_o_sat    <= r_chrom[DIV_STAGES-1] ? r_sq[DIV_STAGES-1] : '0;
        r_o_value  <= r_mx[DIV_STAGES-1];
    end

    assign o_done       = r_o_done;
    assign o_hue        = r_o_hue;
    assign o_hue_valid  = r_o_hvalid;
    assign o_saturation = r_o_sat;
    assign o_value      = r_o_value;

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(LATENCY) o_done)
        else $error("request did not produce a result after the pipeline latency");

    a_no_ghost : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LATENCY))
        else $error("result without a matching request");

    a_achrom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hue_valid) |-> (o_hue == '0 && o_saturation == '0))
        else $error("achromatic result with nonzero hue or saturation");

    a_chrom_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hue_valid) |-> (o_value != '0 && o_saturation != '0))
        else $error("chromatic result with zero value or saturation");
`endif

endmodule
